>>> hw/rtl/sobel_edge_magnitude_rgb_macros.svh
// Assertion helpers for the checker module.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SEM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication checked on every rising clock edge outside reset.
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sed_pkg.sv
package sed_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int CNT_W     = 26;
    localparam int POS_W     = CNT_W + 1;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int NUM_LANES = 3;
    localparam int N_W       = 21;

    // Smallest sum of squares whose rounded root reaches 255.
    localparam logic [N_W-1:0] SAT_LIMIT = N_W'(255 * 254 + 1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic start;
        logic take;
    } lane_ctrl_t;

endpackage

>>> hw/rtl/sed_lane.sv
module sed_lane
    import sed_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic [8:0][CH_W-1:0] win,
    output logic             done,
    output chan_t            mag
);

    typedef enum logic [1:0] {L_IDLE, L_SQUARE, L_ROOT, L_HOLD} lane_state_t;

    lane_state_t state_reg;
    logic [9:0]  ax_reg, ay_reg;
    logic        sat_reg;
    logic [15:0] bits_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  root_reg;
    logic [2:0]  step_reg;
    chan_t       mag_reg;

    logic [10:0]    gx, gy, neg_gx, neg_gy;
    logic [9:0]     ax, ay;
    logic [N_W-1:0] n_sum;
    logic [10:0]    rem_sh, trial;

    always_comb
    begin
        gx = 11'(win[2]) + 11'({win[5], 1'b0}) + 11'(win[8])
           - 11'(win[0]) - 11'({win[3], 1'b0}) - 11'(win[6]);
        gy = 11'(win[6]) + 11'({win[7], 1'b0}) + 11'(win[8])
           - 11'(win[0]) - 11'({win[1], 1'b0}) - 11'(win[2]);
        neg_gx = 11'(0) - gx;
        neg_gy = 11'(0) - gy;
        ax = gx[10] ? neg_gx[9:0] : gx[9:0];
        ay = gy[10] ? neg_gy[9:0] : gy[9:0];
        n_sum = N_W'(ax_reg * ax_reg) + N_W'(ay_reg * ay_reg);
        rem_sh = {rem_reg, bits_reg[15:14]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        ax_reg    <= ax;
                        ay_reg    <= ay;
                        state_reg <= L_SQUARE;
                    end
                end
                L_SQUARE:
                begin
                    sat_reg   <= (n_sum >= SAT_LIMIT);
                    bits_reg  <= n_sum[15:0];
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= L_ROOT;
                end
                L_ROOT:
                begin
                    // One result bit per cycle, remainder kept as n - root^2.
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= 9'(rem_sh - trial);
                        root_reg <= {root_reg[6:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[8:0];
                        root_reg <= {root_reg[6:0], 1'b0};
                    end
                    bits_reg <= {bits_reg[13:0], 2'b00};
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7)
                    begin
                        state_reg <= L_HOLD;
                    end
                end
                L_HOLD:
                begin
                    if (ctrl.take)
                    begin
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // Round half up: the root goes up when the remainder exceeds it; a saturated sum gives 255.
    always_comb
    begin
        if (sat_reg)
        begin
            mag_reg = 8'd255;
        end
        else if ({1'b0, rem_reg} > {2'b00, root_reg})
        begin
            mag_reg = root_reg + 8'd1;
        end
        else
        begin
            mag_reg = root_reg;
        end
    end

    assign done = (state_reg == L_HOLD);
    assign mag  = mag_reg;

endmodule

>>> hw/rtl/sobel_edge_magnitude_rgb.sv
// A result follows the request that completes its window, width+1 requests after its
// pixel, through operand capture, squaring, 8 root steps and the output register.
// Each accepted request stalls the input for the line store read turnaround; a request
// with a result stalls it until each channel lane's iterative root is done and loaded.
// Reset: asynchronous, active low; counters and window clear, registers return to
// 640 x 480, the line stores are not cleared.
module sobel_edge_magnitude_rgb
    import sed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  chan_t       red_in,
    input  chan_t       green_in,
    input  chan_t       blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output chan_t       red_edge,
    output chan_t       green_edge,
    output chan_t       blue_edge,
    output logic        frame_last
);

    typedef enum logic {S_IDLE, S_CALC} top_state_t;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                rd_ok_reg;
    pix_t                up_rd_reg, mid_rd_reg;
    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;
    logic [2:0][2:0][PIX_W-1:0] calc_reg, calc_next;
    logic [COL_W-1:0]    col_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    emit_reg;
    logic [HEIGHT_W-1:0] ei_reg;
    logic [COL_W-1:0]    ej_reg;
    logic                last_reg;
    logic                start_reg;
    top_state_t          state_reg;
    logic                out_valid_reg;
    chan_t [NUM_LANES-1:0] edge_reg;
    logic                frame_last_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                cfg_wr, accept, in_frame, have_out, ignore, wr_en;
    logic                load_out, last_col, emit_last;
    pix_t                pix;
    lane_ctrl_t          ctrl;
    logic [NUM_LANES-1:0] lane_done;
    chan_t [NUM_LANES-1:0] lane_mag;
    logic [NUM_LANES-1:0][8:0][CH_W-1:0] lane_win;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign prdata   = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(height_reg) : 32'(width_reg);
    assign in_stall = !((state_reg == S_IDLE) && rd_ok_reg);
    assign accept   = in_valid && !in_stall;
    assign in_frame = pos_reg < {1'b0, total_reg};
    assign have_out = pos_reg >= (POS_W'(w_eff) + POS_W'(1));
    assign ignore   = cmd && in_frame;
    assign wr_en    = accept && !ignore;
    assign pix      = (!cmd && in_frame) ? {red_in, green_in, blue_in} : '0;
    assign last_col = (POS_W'(col_reg) + POS_W'(1)) >= POS_W'(w_eff);
    assign emit_last = (POS_W'(emit_reg) + POS_W'(1)) >= {1'b0, total_reg};
    assign load_out = (state_reg == S_CALC) && (&lane_done) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        ctrl.start = start_reg;
        ctrl.take  = load_out;
    end

    // Shifted window; at column zero the result uses the old window with the new
    // column left empty, and taps outside the frame border are zeroed.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_rd_reg;
        win_next[1][2] = mid_rd_reg;
        win_next[2][2] = pix;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                calc_next[r][c] = win_next[r][c];
                if (c == 2 && col_reg == '0)
                begin
                    calc_next[r][c] = '0;
                end
                if (r == 0 && ei_reg == '0)
                begin
                    calc_next[r][c] = '0;
                end
                if (r == 2 && (17'(ei_reg) + 17'd1) >= 17'(h_eff))
                begin
                    calc_next[r][c] = '0;
                end
                if (c == 0 && ej_reg == '0)
                begin
                    calc_next[r][c] = '0;
                end
                if (c == 2 && (WIDTH_W'(ej_reg) + WIDTH_W'(1)) >= w_eff)
                begin
                    calc_next[r][c] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[col_reg] <= mid_rd_reg;
        end
        up_rd_reg <= upper_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            middle_mem[col_reg] <= pix;
        end
        mid_rd_reg <= middle_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && have_out)
        begin
            calc_reg <= calc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            total_reg      <= CNT_W'(640 * 480);
            rd_ok_reg      <= 1'b0;
            win_reg        <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            emit_reg       <= '0;
            ei_reg         <= '0;
            ej_reg         <= '0;
            last_reg       <= 1'b0;
            start_reg      <= 1'b0;
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            edge_reg       <= '0;
            frame_last_reg <= 1'b0;
        end
        else
        begin
            total_reg <= CNT_W'(w_eff * h_eff);
            rd_ok_reg <= !(accept || cfg_wr);
            start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                edge_reg       <= lane_mag;
                frame_last_reg <= last_reg;
                state_reg      <= S_IDLE;
            end
            if (cfg_wr)
            begin
                if (paddr[2] == REG_FRAME_WIDTH)
                begin
                    width_reg <= pwdata[WIDTH_W-1:0];
                end
                else
                begin
                    height_reg <= pwdata[HEIGHT_W-1:0];
                end
                col_reg  <= '0;
                pos_reg  <= '0;
                emit_reg <= '0;
                ei_reg   <= '0;
                ej_reg   <= '0;
            end
            else if (wr_en)
            begin
                win_reg <= win_next;
                pos_reg <= pos_reg + POS_W'(1);
                col_reg <= last_col ? '0 : col_reg + COL_W'(1);
                if (have_out)
                begin
                    start_reg <= 1'b1;
                    state_reg <= S_CALC;
                    last_reg  <= (POS_W'(emit_reg) + POS_W'(1)) == {1'b0, total_reg};
                    if (emit_last)
                    begin
                        col_reg  <= '0;
                        pos_reg  <= '0;
                        emit_reg <= '0;
                        ei_reg   <= '0;
                        ej_reg   <= '0;
                    end
                    else
                    begin
                        emit_reg <= emit_reg + CNT_W'(1);
                        if ((WIDTH_W'(ej_reg) + WIDTH_W'(1)) >= w_eff)
                        begin
                            ej_reg <= '0;
                            ei_reg <= ei_reg + HEIGHT_W'(1);
                        end
                        else
                        begin
                            ej_reg <= ej_reg + COL_W'(1);
                        end
                    end
                end
            end
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        for (genvar i = 0; i < 9; i++)
        begin : g_tap
            assign lane_win[k][i] = calc_reg[i / 3][i % 3][PIX_W-1-CH_W*k -: CH_W];
        end

        sed_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .win   (lane_win[k]),
            .done  (lane_done[k]),
            .mag   (lane_mag[k])
        );
    end

    assign out_valid  = out_valid_reg;
    assign red_edge   = edge_reg[0];
    assign green_edge = edge_reg[1];
    assign blue_edge  = edge_reg[2];
    assign frame_last = frame_last_reg;

endmodule

>>> hw/rtl/sed_checker.sv
`include "sobel_edge_magnitude_rgb_macros.svh"

module sed_checker
    import sed_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        in_valid,
    input logic        in_stall,
    input logic        cmd,
    input chan_t       red_in,
    input chan_t       green_in,
    input chan_t       blue_in,
    input logic        out_valid,
    input logic        out_stall,
    input chan_t       red_edge,
    input chan_t       green_edge,
    input chan_t       blue_edge,
    input logic        frame_last
);

    // An accepted request is followed by a stall while the line stores catch up.
    `SEM_ASSERT_IMPL(a_stall_after_accept, in_valid && !in_stall, in_stall, "accept without turnaround")

    // A register write restarts the frame and refreshes the store read.
    `SEM_ASSERT_IMPL(a_stall_after_cfg, psel && penable && pwrite, in_stall, "accept right after config")

    `SEM_ASSERT_IMPL(a_out_hold, out_valid && out_stall,
        out_valid && $stable(red_edge) && $stable(green_edge) && $stable(blue_edge)
        && $stable(frame_last), "stalled result changed")

endmodule

bind sobel_edge_magnitude_rgb sed_checker u_sed_checker (.*);

>>> verif/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;
    import sed_pkg::*;

    localparam logic [2:0] REG_ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] REG_ADDR_HEIGHT = 3'd4;
    localparam int LIMIT_CYCLES    = 1200000;
    localparam logic CMD_PIXEL     = 1'b0;
    localparam logic CMD_DRAIN     = 1'b1;

    typedef struct packed {
        logic  cmd;
        chan_t r;
        chan_t g;
        chan_t b;
    } request_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        logic  last;
    } edge_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    chan_t       red_in = '0, green_in = '0, blue_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    chan_t       red_edge, green_edge, blue_edge;
    logic        frame_last;

    sobel_edge_magnitude_rgb u_dut (.*);

    always #2 clk = ~clk;

    // Predictor state.
    int unsigned cfg_width, cfg_height;
    pix_t        upper_row [MAX_WIDTH];
    pix_t        middle_row [MAX_WIDTH];
    pix_t        win [9];
    int unsigned col_pos, row_pos, edges_done;

    request_t pending_requests[$];
    edge_t    expected_edges[$];
    int       errors = 0;
    int       edges_seen = 0;
    int       frames_seen = 0;
    int       requests_seen = 0;
    int       cycle = 0;
    bit       quiet_mode = 1'b0;
    bit       out_hold = 1'b0;
    bit       in_taken = 1'b0;

    function automatic int unsigned used_width();
        int unsigned w;
        w = cfg_width & 11'h7ff;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned used_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic chan_t rounded_magnitude(int gx, int gy);
        int unsigned n, s, t;
        n = gx * gx + gy * gy;
        if (n >= 255 * 254 + 1) return 8'd255;
        s = 0;
        for (int b = 128; b != 0; b >>= 1)
        begin
            t = s | b;
            if (t * t <= n) s = t;
        end
        if (n - s * s > s) s++;
        return chan_t'(s);
    endfunction

    // Builds the edge result for window columns starting at first_col (3 = zero).
    function automatic edge_t window_edge(int first_col, int unsigned w, int unsigned h);
        pix_t        p [9];
        int unsigned i, j;
        int          src, gx, gy, sh;
        chan_t       mag [3];
        edge_t       e;
        i = edges_done / w;
        j = edges_done % w;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                src = first_col + c;
                p[r*3+c] = (src < 3) ? win[r*3+src] : '0;
                if (r == 0 && i == 0) p[r*3+c] = '0;
                if (r == 2 && i + 1 >= h) p[r*3+c] = '0;
                if (c == 0 && j == 0) p[r*3+c] = '0;
                if (c == 2 && j + 1 >= w) p[r*3+c] = '0;
            end
        for (int k = 0; k < 3; k++)
        begin
            sh = 16 - 8 * k;
            gx = int'(p[2][sh+:8]) + 2*int'(p[5][sh+:8]) + int'(p[8][sh+:8])
               - int'(p[0][sh+:8]) - 2*int'(p[3][sh+:8]) - int'(p[6][sh+:8]);
            gy = int'(p[6][sh+:8]) + 2*int'(p[7][sh+:8]) + int'(p[8][sh+:8])
               - int'(p[0][sh+:8]) - 2*int'(p[1][sh+:8]) - int'(p[2][sh+:8]);
            mag[k] = rounded_magnitude(gx, gy);
        end
        e.r = mag[0];
        e.g = mag[1];
        e.b = mag[2];
        e.last = (edges_done + 1 == w * h);
        return e;
    endfunction

    task automatic predict_edge(request_t q);
        int unsigned w, h, total, c, pos;
        bit          have, made;
        pix_t        px, up, mid;
        edge_t       e;
        w = used_width();
        h = used_height();
        total = w * h;
        c = col_pos;
        pos = row_pos * w + c;
        have = pos >= w + 1;
        made = 1'b0;
        px = '0;
        if (q.cmd == CMD_DRAIN && pos < total) return;
        if (q.cmd == CMD_PIXEL && pos < total) px = {q.r, q.g, q.b};
        if (c >= MAX_WIDTH) c = 0;
        if (c == 0 && have)
        begin
            e = window_edge(1, w, h);
            made = 1'b1;
        end
        up = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = px;
        for (int r = 0; r < 3; r++)
        begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        if (c != 0 && have)
        begin
            e = window_edge(0, w, h);
            made = 1'b1;
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
            col_pos = c + 1;
        if (made)
        begin
            expected_edges.push_back(e);
            edges_done++;
            if (edges_done >= total)
            begin
                col_pos = 0;
                row_pos = 0;
                edges_done = 0;
            end
        end
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_ADDR_WIDTH) cfg_width = data & 32'h7ff;
        else cfg_height = data & 32'hffff;
        col_pos = 0;
        row_pos = 0;
        edges_done = 0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_edges.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic request_t random_pixel();
        request_t q;
        q.cmd = CMD_PIXEL;
        case ($urandom_range(0, 5))
            0: {q.r, q.g, q.b} = '0;
            1: {q.r, q.g, q.b} = '1;
            default: {q.r, q.g, q.b} = 24'($urandom);
        endcase
        return q;
    endfunction

    // Queues one whole frame plus its drain requests, with noise mixed in when noisy is set.
    task automatic queue_frame(int unsigned w, int unsigned h, bit noisy);
        request_t q;
        for (int k = 0; k < w * h; k++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
            begin
                q = random_pixel();
                q.cmd = CMD_DRAIN;
                pending_requests.push_back(q);
            end
            pending_requests.push_back(random_pixel());
        end
        for (int k = 0; k <= w; k++)
        begin
            q = random_pixel();
            if (!noisy || $urandom_range(0, 1)) q.cmd = CMD_DRAIN;
            pending_requests.push_back(q);
        end
    endtask

    // Driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_requests.size() != 0 &&
                    (quiet_mode || $urandom_range(0, 99) >= 13))
                begin
                    {cmd, red_in, green_in, blue_in} <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= out_hold || (!quiet_mode && $urandom_range(0, 99) < 13);
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge clk)
    begin
        edge_t want;
        cycle <= cycle + 1;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            predict_edge({cmd, red_in, green_in, blue_in});
            requests_seen <= requests_seen + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            edges_seen <= edges_seen + 1;
            if (frame_last) frames_seen <= frames_seen + 1;
            if (expected_edges.size() == 0)
            begin
                $error("unexpected edge result %0h %0h %0h last %0b",
                       red_edge, green_edge, blue_edge, frame_last);
                errors++;
            end
            else
            begin
                want = expected_edges.pop_front();
                if (red_edge !== want.r)
                begin
                    $error("red_edge expected %0d actual %0d", want.r, red_edge);
                    errors++;
                end
                if (green_edge !== want.g)
                begin
                    $error("green_edge expected %0d actual %0d", want.g, green_edge);
                    errors++;
                end
                if (blue_edge !== want.b)
                begin
                    $error("blue_edge expected %0d actual %0d", want.b, blue_edge);
                    errors++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last expected %0b actual %0b", want.last, frame_last);
                    errors++;
                end
            end
        end
        if (cycle >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        request_t q;
        int unsigned w, h;
        cfg_width = 640;
        cfg_height = 480;
        col_pos = 0;
        row_pos = 0;
        edges_done = 0;
        foreach (win[k]) win[k] = '0;
        foreach (upper_row[k])
        begin
            upper_row[k] = '0;
            middle_row[k] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: one-pixel frame, extremes, early drain, pixel used as drain.
        write_reg(REG_ADDR_WIDTH, 0);
        write_reg(REG_ADDR_HEIGHT, 0);
        q = '{CMD_DRAIN, 8'hff, 8'hff, 8'hff};
        pending_requests.push_back(q);
        q = '{CMD_PIXEL, 8'hff, 8'hff, 8'hff};
        pending_requests.push_back(q);
        q = '{CMD_PIXEL, 8'h00, 8'h00, 8'h00};
        pending_requests.push_back(q);
        q.cmd = CMD_DRAIN;
        pending_requests.push_back(q);
        wait_idle();
        // A 3x3 checkerboard of extremes drives the saturation path.
        write_reg(REG_ADDR_WIDTH, 3);
        write_reg(REG_ADDR_HEIGHT, 3);
        for (int k = 0; k < 9; k++)
        begin
            q.cmd = CMD_PIXEL;
            {q.r, q.g, q.b} = (k % 2) ? 24'hffffff : 24'h00ff00;
            pending_requests.push_back(q);
        end
        for (int k = 0; k < 4; k++)
        begin
            q.cmd = CMD_DRAIN;
            pending_requests.push_back(q);
        end
        wait_idle();

        // One row, one column, and a long row whose configured width exceeds the line store.
        write_reg(REG_ADDR_WIDTH, 5);
        write_reg(REG_ADDR_HEIGHT, 1);
        queue_frame(5, 1, 0);
        wait_idle();
        write_reg(REG_ADDR_WIDTH, 1);
        write_reg(REG_ADDR_HEIGHT, 6);
        queue_frame(1, 6, 0);
        wait_idle();
        // The clamped 1024-wide frame is cut short after its first few results.
        write_reg(REG_ADDR_WIDTH, 2047);
        write_reg(REG_ADDR_HEIGHT, 2);
        for (int k = 0; k < 1030; k++) pending_requests.push_back(random_pixel());
        wait_idle();

        // Long receiver hold while the sender keeps offering.
        write_reg(REG_ADDR_WIDTH, 4);
        write_reg(REG_ADDR_HEIGHT, 4);
        fork
            begin
                out_hold = 1'b1;
                repeat (300) @(negedge clk);
                out_hold = 1'b0;
            end
        join_none
        queue_frame(4, 4, 0);
        wait_idle();

        // Quiet stretch with no idling on either side.
        quiet_mode = 1'b1;
        write_reg(REG_ADDR_WIDTH, 8);
        write_reg(REG_ADDR_HEIGHT, 6);
        queue_frame(8, 6, 0);
        wait_idle();
        quiet_mode = 1'b0;

        // Random frames, small sizes; the sender pauses for the results at each one.
        while (requests_seen < 1700)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            write_reg(REG_ADDR_WIDTH, w);
            write_reg(REG_ADDR_HEIGHT, h);
            queue_frame(w, h, $urandom_range(0, 3) == 0);
            // Split a frame, so the next register write can hit mid-frame idle.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5)) pending_requests.push_back(random_pixel());
            wait_idle();
        end
        write_reg(REG_ADDR_HEIGHT, 65535);
        write_reg(REG_ADDR_WIDTH, 2);
        for (int k = 0; k < 40; k++) pending_requests.push_back(random_pixel());
        wait_idle();
        write_reg(REG_ADDR_WIDTH, 640);
        write_reg(REG_ADDR_HEIGHT, 480);
        wait_idle();

        $display("checked %0d edge results from %0d requests over %0d completed frames",
                 edges_seen, requests_seen, frames_seen);
        $display("frame sizes from 1x1 up to 1024-pixel rows, plus stalls and stray drains");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sed_pkg.sv
hw/rtl/sed_lane.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
hw/rtl/sed_checker.sv
verif/sobel_edge_magnitude_rgb_tb.sv
